[rtl/wind_vane_heading_filter_defines.svh]
// Assertion macros for the wind vane heading filter checker.
// Used by whf_checker.sv; depends on nothing else.
`ifndef WIND_VANE_HEADING_FILTER_DEFINES_SVH
`define WIND_VANE_HEADING_FILTER_DEFINES_SVH

// Clocked assertion that is ignored while reset is high.
`define WHF_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("wind vane heading filter: assertion failed");

// Clocked assertion that is also checked across reset.
`define WHF_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("wind vane heading filter: reset assertion failed");

`endif

[rtl/whf_pkg.sv]
// Shared constants and types for the wind vane heading filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package whf_pkg;

  // Field widths
  localparam int RAW_W    = 12;
  localparam int SAMPLE_W = 15;
  localparam int OFFSET_W = 10;
  localparam int SECTOR_W = 4;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  // Register index decode (paddr[2] selects the word)
  localparam logic REG_IDX_OFFSET = 1'b0;

  // Averaging window
  localparam int WINDOW_DEPTH = 400;
  localparam int WIDX_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SAMPLE_MAX   = 22800;
  localparam int SUM_W        = $clog2(longint'(SAMPLE_MAX) * WINDOW_DEPTH + 1);

  // Sum / WINDOW_DEPTH by reciprocal multiply, exact over the whole sum range
  localparam int AVG_SHIFT = SUM_W + $clog2(WINDOW_DEPTH);
  localparam longint unsigned AVG_RECIP_L =
    ((64'd1 << AVG_SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
  localparam int AVG_RECIP_W = $clog2(AVG_RECIP_L + 1);
  localparam logic [AVG_RECIP_W-1:0] AVG_RECIP = AVG_RECIP_W'(AVG_RECIP_L);
  localparam int AVG_PROD_W = SUM_W + AVG_RECIP_W;

  // Raw count to Q9.6 degrees: raw * 5568 / 1000 == raw * 696 / 125
  localparam int CONV_MUL = 696;
  localparam int CONV_DIV = 125;
  localparam int CONV_X_W = $clog2(((1 << RAW_W) - 1) * CONV_MUL + 1);
  localparam int CONV_SHIFT = CONV_X_W + $clog2(CONV_DIV);
  localparam longint unsigned CONV_RECIP_L =
    ((64'd1 << CONV_SHIFT) + CONV_DIV - 1) / CONV_DIV;
  localparam int CONV_RECIP_W = $clog2(CONV_RECIP_L + 1);
  localparam logic [CONV_RECIP_W-1:0] CONV_RECIP = CONV_RECIP_W'(CONV_RECIP_L);
  localparam int CONV_PROD_W = CONV_X_W + CONV_RECIP_W;

  // Angle constants in Q9.6
  localparam int Q6_FULL_TURN   = 23040;
  localparam int Q6_JUMP_LIMIT  = 5760;
  localparam int Q6_HALF_SECTOR = 720;
  localparam int Q6_SECTOR      = 1440;
  localparam int OFFSET_LIMIT   = 359;
  localparam int HEAD_S_W       = SAMPLE_W + 2;

  // Sector index: (heading + half sector) / sector by reciprocal multiply
  localparam int SECT_IN_W  = SAMPLE_W;
  localparam int SECT_SHIFT = SECT_IN_W + $clog2(Q6_SECTOR);
  localparam longint unsigned SECT_RECIP_L =
    ((64'd1 << SECT_SHIFT) + Q6_SECTOR - 1) / Q6_SECTOR;
  localparam int SECT_RECIP_W = $clog2(SECT_RECIP_L + 1);
  localparam logic [SECT_RECIP_W-1:0] SECT_RECIP = SECT_RECIP_W'(SECT_RECIP_L);
  localparam int SECT_PROD_W = SECT_IN_W + SECT_RECIP_W;

  // Sample queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic                valid;
    logic [SAMPLE_W-1:0] sample;
  } samp_beat_t;

endpackage

`default_nettype wire

[rtl/wind_vane_heading_filter.sv]
// Wind vane heading filter top level: queue-style channels and APB register port.
// Depends on whf_pkg, whf_front, whf_queue and whf_back.
//
// Usage:
//  - Input channel: drive raw_angle and push; a beat is taken at a clock edge with
//    push high and full low. full rises when the converter pipe and the
//    sample queue together hold QUEUE_DEPTH beats.
//  - Result channel: while empty is low, heading_q6 / sector / jump_reset show the
//    oldest result; pop high at a clock edge takes it.
//  - Exactly one result per input beat, in order.
//  - Path of a sample: the converter registers, the sample queue, then the back-end
//    states idle, check, accumulate or fill, divide, average, heading, sector and
//    output; a sample more than 90 degrees off the last average refills the whole
//    window, one entry per cycle, in the fill state.
//  - The back-end sequencer works on one sample at a time and takes no new one
//    until the last result has gone into the result register.
//  - Reset (rst, synchronous): window reads as all zero, sum, average and
//    write index clear, direction_offset is 0, both channels empty.
//  - A stalled receiver holds the result; the back end waits with the next
//    result and the queue fills, then full goes high.
//  - Write direction_offset at byte address 0 while the block is idle.
`default_nettype none

module wind_vane_heading_filter (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input channel
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [whf_pkg::RAW_W-1:0]     raw_angle,
  // result channel
  output logic                               empty,
  input  wire logic                          pop,
  output logic [whf_pkg::SAMPLE_W-1:0]       heading_q6,
  output logic [whf_pkg::SECTOR_W-1:0]       sector,
  output logic                               jump_reset,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [whf_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [whf_pkg::DATA_W-1:0]    pwdata,
  output logic [whf_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);
  import whf_pkg::*;

  logic signed [OFFSET_W-1:0] direction_offset;
  logic                       cfg_wr;
  samp_beat_t                 front_beat;
  samp_beat_t                 q_head;
  logic [QCNT_W-1:0]          q_count;
  logic                       deq;
  logic                       res_valid;
  logic                       res_pop;

  // Configuration: single signed offset register, always ready.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction_offset <= '0;
    end else if (cfg_wr && (paddr[2] == REG_IDX_OFFSET)) begin
      direction_offset <= pwdata[OFFSET_W-1:0];
    end
  end

  // Read back sign-extended; unmapped words read zero.
  assign prdata = (paddr[2] == REG_IDX_OFFSET) ?
                  DATA_W'(direction_offset) : '0;

  // Convert raw counts and park them in the queue.
  whf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .raw_angle (raw_angle),
    .q_count   (q_count),
    .full      (full),
    .beat      (front_beat)
  );

  whf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .in_beat (front_beat),
    .deq     (deq),
    .head    (q_head),
    .count   (q_count)
  );

  // Average, calibrate and hold the result until popped.
  assign res_pop = pop && res_valid;
  assign empty   = !res_valid;

  whf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (q_head),
    .deq         (deq),
    .offset      (direction_offset),
    .res_pop     (res_pop),
    .res_valid   (res_valid),
    .res_heading (heading_q6),
    .res_sector  (sector),
    .res_jump    (jump_reset)
  );

endmodule

`default_nettype wire

[rtl/whf_front.sv]
// Front end: accepts raw vane counts and converts them to Q9.6 degrees.
// Depends on whf_pkg; feeds whf_queue.
`default_nettype none

module whf_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  input  wire logic [whf_pkg::RAW_W-1:0]    raw_angle,
  input  wire logic [whf_pkg::QCNT_W-1:0]   q_count,
  output logic                              full,
  output whf_pkg::samp_beat_t               beat
);
  import whf_pkg::*;

  logic                   v1;
  logic                   v2;
  logic [CONV_X_W-1:0]    x1;
  logic [SAMPLE_W-1:0]    sample2;
  logic [CONV_PROD_W-1:0] conv_prod;
  logic [QCNT_W-1:0]      occupancy;

  // Reserve a queue slot for every beat still in the conversion pipe.
  assign occupancy = q_count + QCNT_W'(v1) + QCNT_W'(v2);
  assign full      = (occupancy >= QCNT_W'(QUEUE_DEPTH));

  assign conv_prod = CONV_PROD_W'(x1) * CONV_PROD_W'(CONV_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= push && !full;
      v2 <= v1;
      x1 <= CONV_X_W'(raw_angle) * CONV_X_W'(CONV_MUL);
      sample2 <= conv_prod[CONV_SHIFT +: SAMPLE_W];
    end
  end

  assign beat.valid  = v2;
  assign beat.sample = sample2;

endmodule

`default_nettype wire

[rtl/whf_queue.sv]
// Short sample queue that decouples the converter from the averaging back end.
// Depends on whf_pkg.
`default_nettype none

module whf_queue (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire whf_pkg::samp_beat_t         in_beat,
  input  wire logic                        deq,
  output whf_pkg::samp_beat_t              head,
  output logic [whf_pkg::QCNT_W-1:0]       count
);
  import whf_pkg::*;

  logic [SAMPLE_W-1:0] slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic                do_deq;

  assign do_deq      = deq && (count != '0);
  assign head.valid  = (count != '0);
  assign head.sample = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_beat.valid) begin
      slots[wr_ptr] <= in_beat.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_beat.valid) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_deq) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({in_beat.valid, do_deq})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/whf_back.sv]
// Back end: window store, running sum, average, calibration, sector and result register.
// Depends on whf_pkg; takes samples from whf_queue.
`default_nettype none

module whf_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire whf_pkg::samp_beat_t               head,
  output logic                                   deq,
  input  wire logic signed [whf_pkg::OFFSET_W-1:0] offset,
  input  wire logic                              res_pop,
  output logic                                   res_valid,
  output logic [whf_pkg::SAMPLE_W-1:0]           res_heading,
  output logic [whf_pkg::SECTOR_W-1:0]           res_sector,
  output logic                                   res_jump
);
  import whf_pkg::*;

  localparam int STATE_W = 4;
  localparam logic [STATE_W-1:0] S_IDLE  = 4'd0;
  localparam logic [STATE_W-1:0] S_CHECK = 4'd1;
  localparam logic [STATE_W-1:0] S_ACCUM = 4'd2;
  localparam logic [STATE_W-1:0] S_FILL  = 4'd3;
  localparam logic [STATE_W-1:0] S_DIV   = 4'd4;
  localparam logic [STATE_W-1:0] S_AVG   = 4'd5;
  localparam logic [STATE_W-1:0] S_HEAD  = 4'd6;
  localparam logic [STATE_W-1:0] S_SECT  = 4'd7;
  localparam logic [STATE_W-1:0] S_OUT   = 4'd8;

  logic [STATE_W-1:0]     state;
  logic [SAMPLE_W-1:0]    mem [WINDOW_DEPTH];
  logic [SAMPLE_W-1:0]    mem_rdata;
  logic                   mem_we;
  logic [WIDX_W-1:0]      mem_waddr;

  logic [WIDX_W-1:0]      windex;
  logic [WIDX_W-1:0]      windex_adv;
  logic                   windex_wrap;
  logic                   filled;
  logic [WIDX_W-1:0]      fill_idx;
  logic [SUM_W-1:0]       sum;
  logic [SAMPLE_W-1:0]    last_avg;
  logic [SAMPLE_W-1:0]    sample;
  logic                   jump;
  logic [AVG_PROD_W-1:0]  avg_prod;
  logic [SAMPLE_W-1:0]    heading;
  logic [SECT_PROD_W-1:0] sect_prod;

  logic [SAMPLE_W-1:0]        delta;
  logic                       jump_c;
  logic [SAMPLE_W-1:0]        old_entry;
  logic signed [OFFSET_W-1:0] off_c;
  logic signed [HEAD_S_W-1:0] off_q6;
  logic signed [HEAD_S_W-1:0] head_s;
  logic signed [HEAD_S_W-1:0] head_w;
  logic [SAMPLE_W-1:0]        heading_c;
  logic [SECT_IN_W-1:0]       sect_in;
  logic                       res_free;
  logic                       res_load;

  // Window store: one write port, one registered read at the write index.
  assign mem_we    = (state == S_ACCUM) || (state == S_FILL);
  assign mem_waddr = (state == S_FILL) ? fill_idx : windex;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= sample;
    end
    mem_rdata <= mem[windex];
  end

  // Entries ahead of the first full pass are still at their reset value.
  assign old_entry   = filled ? mem_rdata : '0;
  assign windex_wrap = (windex == WIDX_W'(WINDOW_DEPTH - 1));
  assign windex_adv  = windex_wrap ? '0 : windex + 1'b1;

  assign delta  = (sample > last_avg) ? sample - last_avg : last_avg - sample;
  assign jump_c = (delta > SAMPLE_W'(Q6_JUMP_LIMIT));

  always_comb begin
    off_c = offset;
    if (offset < -OFFSET_W'(OFFSET_LIMIT)) begin
      off_c = -OFFSET_W'(OFFSET_LIMIT);
    end else if (offset > OFFSET_W'(OFFSET_LIMIT)) begin
      off_c = OFFSET_W'(OFFSET_LIMIT);
    end
    off_q6 = HEAD_S_W'(off_c) <<< 6;
    head_s = $signed({2'b00, last_avg}) + off_q6;
    head_w = head_s;
    if (head_s > HEAD_S_W'(Q6_FULL_TURN)) begin
      head_w = head_s - HEAD_S_W'(Q6_FULL_TURN);
    end else if (head_s < 0) begin
      head_w = head_s + HEAD_S_W'(Q6_FULL_TURN);
    end
    heading_c = head_w[SAMPLE_W-1:0];
  end

  assign sect_in  = heading + SECT_IN_W'(Q6_HALF_SECTOR);
  assign res_free = !res_valid || res_pop;
  assign res_load = (state == S_OUT) && res_free;
  assign deq      = (state == S_IDLE) && head.valid;

  // Result register: load a new beat or drop the popped one.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      windex    <= '0;
      filled    <= 1'b0;
      sum       <= '0;
      last_avg  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (head.valid) begin
            sample <= head.sample;
            state  <= S_CHECK;
          end
        end
        S_CHECK: begin
          jump     <= jump_c;
          fill_idx <= '0;
          if (jump_c) begin
            sum   <= SUM_W'(sample) * SUM_W'(WINDOW_DEPTH);
            state <= S_FILL;
          end else begin
            state <= S_ACCUM;
          end
        end
        S_ACCUM: begin
          sum    <= sum - SUM_W'(old_entry) + SUM_W'(sample);
          windex <= windex_adv;
          if (windex_wrap) begin
            filled <= 1'b1;
          end
          state <= S_DIV;
        end
        S_FILL: begin
          fill_idx <= fill_idx + 1'b1;
          if (fill_idx == WIDX_W'(WINDOW_DEPTH - 1)) begin
            windex <= windex_adv;
            filled <= 1'b1;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          avg_prod <= AVG_PROD_W'(sum) * AVG_PROD_W'(AVG_RECIP);
          state    <= S_AVG;
        end
        S_AVG: begin
          last_avg <= avg_prod[AVG_SHIFT +: SAMPLE_W];
          state    <= S_HEAD;
        end
        S_HEAD: begin
          heading <= heading_c;
          state   <= S_SECT;
        end
        S_SECT: begin
          sect_prod <= SECT_PROD_W'(sect_in) * SECT_PROD_W'(SECT_RECIP);
          state     <= S_OUT;
        end
        S_OUT: begin
          if (res_free) begin
            res_heading <= heading;
            res_sector  <= sect_prod[SECT_SHIFT +: SECTOR_W];
            res_jump    <= jump;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/whf_checker.sv]
// Port-level checker for the wind vane heading filter, bound to the top level.
// Depends on whf_pkg and wind_vane_heading_filter_defines.svh.
`default_nettype none
`include "wind_vane_heading_filter_defines.svh"

module whf_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         full,
  input wire logic                         empty,
  input wire logic                         pop,
  input wire logic [whf_pkg::SAMPLE_W-1:0] heading_q6,
  input wire logic [whf_pkg::SECTOR_W-1:0] sector,
  input wire logic                         jump_reset
);
  import whf_pkg::*;

  logic [SAMPLE_W:0] sect_pos;
  logic [SAMPLE_W:0] sect_lo;
  logic              sect_ok;

  // Sector must bracket the heading shifted by half a sector.
  always_comb begin
    sect_pos = (SAMPLE_W + 1)'(heading_q6) + (SAMPLE_W + 1)'(Q6_HALF_SECTOR);
    sect_lo  = (SAMPLE_W + 1)'(sector) * (SAMPLE_W + 1)'(Q6_SECTOR);
    sect_ok  = ((sect_pos >= sect_lo) &&
                (sect_pos < sect_lo + (SAMPLE_W + 1)'(Q6_SECTOR))) ||
               ((sector == '0) && (sect_pos >= (SAMPLE_W + 1)'(Q6_FULL_TURN)));
  end

  `WHF_ASSERT_RST(a_reset_idle, clk, rst |=> empty && !full)
  `WHF_ASSERT(a_heading_range, clk, rst, !empty |-> heading_q6 <= SAMPLE_W'(Q6_FULL_TURN))
  `WHF_ASSERT(a_sector_match, clk, rst, !empty |-> sect_ok)
  `WHF_ASSERT(a_result_holds, clk, rst, !empty && !pop |=> !empty && $stable(heading_q6) && $stable(sector) && $stable(jump_reset))

endmodule

bind wind_vane_heading_filter whf_checker u_whf_checker (.*);

`default_nettype wire

[sim/wind_vane_heading_filter_tb.sv]
// Self-checking testbench for the wind vane heading filter: directed corner cases,
// then random heading walks under random push gaps and pop stalls.
// Depends on whf_pkg and the wind_vane_heading_filter RTL.
`default_nettype none

module wind_vane_heading_filter_tb;
  import whf_pkg::*;

  // Raw count to Q9.6 degrees: 0.087 degree per count, floored
  localparam int COUNT_TO_Q6_NUM = 5568;
  localparam int COUNT_TO_Q6_DEN = 1000;
  localparam int DEG_TO_Q6       = 64;

  localparam logic [RAW_W-1:0]  RAW_MIN = '0;
  localparam logic [RAW_W-1:0]  RAW_MAX = '1;
  localparam logic [ADDR_W-1:0] OFFSET_ADDR   = 3'd0;  // direction_offset
  localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = 3'd4;  // no register behind it
  localparam int OFFSET_INDEX = 0;

  // Q9.6 headings that sit exactly on a special boundary
  localparam int Q6_SSW_EDGE = 12240;  // 191.25 degrees
  localparam int Q6_N_EDGE   = 22320;  // 348.75 degrees

  localparam int SETTLE_CYCLES  = 24;
  localparam int WALK_PHASES    = 6;
  localparam int PHASE_BEATS    = 250;
  localparam int WATCHDOG_DELAY = 60_000_000;  // several times the worst run

  typedef struct packed {
    logic [SAMPLE_W-1:0] heading_q6;
    logic [SECTOR_W-1:0] sector;
    logic                jump_reset;
  } heading_beat_t;

  logic                clk;
  logic                rst;
  logic                push;
  logic                full;
  logic [RAW_W-1:0]    raw_angle;
  logic                empty;
  logic                pop;
  logic [SAMPLE_W-1:0] heading_q6;
  logic [SECTOR_W-1:0] sector;
  logic                jump_reset;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Shadow of the filter: window contents, slot pointer, sum, mean and offset
  int                  window_q6 [WINDOW_DEPTH];
  int                  window_slot;
  int                  window_sum;
  int                  mean_q6;
  logic [OFFSET_W-1:0] offset_reg;

  // Headings predicted for accepted samples, oldest first
  heading_beat_t       pending_headings[$];
  heading_beat_t       oldest_heading;

  int burst_left;
  int fail_count;
  int samples_sent;
  int headings_checked;
  int refill_count;
  int offset_writes;

  logic [31:0] pop_pattern = '1;
  logic [6:0]  pop_tick = '0;

  wind_vane_heading_filter DUT (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .raw_angle  (raw_angle),
    .empty      (empty),
    .pop        (pop),
    .heading_q6 (heading_q6),
    .sector     (sector),
    .jump_reset (jump_reset),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int raw_to_q6(input int raw);
    return raw * COUNT_TO_Q6_NUM / COUNT_TO_Q6_DEN;
  endfunction

  // Smallest raw count that lands exactly on a Q9.6 value, or -1 if none does
  function automatic int raw_at_q6(input int q6);
    int r;
    if (q6 < 0 || q6 > SAMPLE_MAX) return -1;
    r = (q6 * COUNT_TO_Q6_DEN + COUNT_TO_Q6_NUM - 1) / COUNT_TO_Q6_NUM;
    if (r <= int'(RAW_MAX) && raw_to_q6(r) == q6) return r;
    return -1;
  endfunction

  // Advance the shadow filter by one sample and return the heading it yields
  function automatic heading_beat_t advance_heading_filter(input logic [RAW_W-1:0] raw);
    heading_beat_t beat;
    int q6;
    int delta;
    int deg;
    int head;
    q6    = raw_to_q6(int'(raw));
    delta = q6 - mean_q6;
    if (delta < 0) delta = -delta;
    beat.jump_reset = (delta > Q6_JUMP_LIMIT);
    if (beat.jump_reset) begin
      // Far off the mean: flood the whole window with this sample
      foreach (window_q6[i]) window_q6[i] = q6;
      window_sum = q6 * WINDOW_DEPTH;
      refill_count++;
    end else begin
      window_sum = window_sum - window_q6[window_slot] + q6;
      window_q6[window_slot] = q6;
    end
    window_slot = (window_slot + 1) % WINDOW_DEPTH;
    mean_q6 = window_sum / WINDOW_DEPTH;
    // Clamp the calibration to +/-359 degrees so one wrap always suffices
    deg = int'($signed(offset_reg));
    if (deg < -OFFSET_LIMIT) deg = -OFFSET_LIMIT;
    if (deg > OFFSET_LIMIT) deg = OFFSET_LIMIT;
    head = mean_q6 + deg * DEG_TO_Q6;
    // Exactly 360 degrees stays; only strictly above wraps down
    if (head > Q6_FULL_TURN) head -= Q6_FULL_TURN;
    else if (head < 0) head += Q6_FULL_TURN;
    beat.heading_q6 = SAMPLE_W'(head);
    beat.sector     = SECTOR_W'((head + Q6_HALF_SECTOR) / Q6_SECTOR);
    return beat;
  endfunction

  // Offer one sample on the input queue; called and returning at a falling edge.
  // Bursts of random length are separated by random gaps with push low.
  task automatic send_angle(input logic [RAW_W-1:0] raw);
    int gap;
    int roll;
    if (burst_left == 0) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) gap = 0;
      else if (roll < 85) gap = $urandom_range(1, 4);
      else if (roll < 97) gap = $urandom_range(5, 12);
      else gap = $urandom_range(20, 40);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(1, 16);
    end
    push      <= 1'b1;
    raw_angle <= raw;
    do @(posedge clk); while (full);
    pending_headings.push_back(advance_heading_filter(raw));
    samples_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // Hold push low until every predicted heading has been popped, then let the
  // pipe settle; ends at a falling edge
  task automatic wait_for_drain();
    push <= 1'b0;
    burst_left = 0;
    while (pending_headings.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle; only issued with the block idle
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    wait_for_drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (int'(addr >> 2) == OFFSET_INDEX) offset_reg = data[OFFSET_W-1:0];
    offset_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Force the window to be refilled with one sample: first bounce to an
  // extreme that is surely a jump, then to the far extreme if needed
  task automatic refill_to(input logic [RAW_W-1:0] raw);
    int delta;
    if (mean_q6 > Q6_JUMP_LIMIT) send_angle(RAW_MIN);
    else send_angle(RAW_MAX);
    delta = raw_to_q6(int'(raw)) - mean_q6;
    if (delta < 0) delta = -delta;
    if (delta <= Q6_JUMP_LIMIT) send_angle((mean_q6 == 0) ? RAW_MAX : RAW_MIN);
    send_angle(raw);
  endtask

  // Pick an offset and a raw count whose refilled mean gives this exact heading
  task automatic steer_heading(input int target);
    int o;
    int r;
    r = -1;
    for (o = -OFFSET_LIMIT; o <= OFFSET_LIMIT; o++) begin
      r = raw_at_q6(target - o * DEG_TO_Q6);
      if (r >= 0) break;
    end
    write_reg(OFFSET_ADDR, DATA_W'(o));
    refill_to(RAW_W'(r));
  endtask

  // Fresh window after reset: small samples must not count as jumps
  task automatic check_reset_state();
    send_angle(RAW_MIN);
    send_angle(RAW_W'(1));
    send_angle(RAW_W'(2));
  endtask

  // Distance of exactly 90 degrees keeps the window, one Q9.6 step more refills it
  task automatic check_jump_threshold();
    int base;
    int partner;
    partner = -1;
    for (base = 0; base <= int'(RAW_MAX); base++) begin
      partner = raw_at_q6(raw_to_q6(base) + Q6_JUMP_LIMIT);
      if (partner >= 0) break;
    end
    refill_to(RAW_W'(base));
    send_angle(RAW_W'(partner));
    for (base = int'(RAW_MAX); base >= 0; base--) begin
      partner = raw_at_q6(raw_to_q6(base) - Q6_JUMP_LIMIT - 1);
      if (partner >= 0) break;
    end
    refill_to(RAW_W'(base));
    send_angle(RAW_W'(partner));
  endtask

  // Full turn stays unwrapped; sector edges at 191.25 and 348.75 degrees
  task automatic check_boundary_headings();
    steer_heading(Q6_FULL_TURN);
    steer_heading(Q6_SSW_EDGE);
    steer_heading(Q6_N_EDGE);
  endtask

  // Offsets beyond +/-359 clamp; drive wrap above 360 and below 0
  task automatic check_offset_clamp();
    write_reg(OFFSET_ADDR, DATA_W'(10'h1FF));
    send_angle(RAW_MAX);
    send_angle(RAW_MAX);
    write_reg(OFFSET_ADDR, DATA_W'(10'h200));
    send_angle(RAW_MIN);
    send_angle(RAW_MIN);
  endtask

  // A write to an address with no register must leave the offset alone
  task automatic check_unmapped_write();
    write_reg(UNMAPPED_ADDR, DATA_W'(32'h0000_0123));
    send_angle(RAW_W'(2048));
  endtask

  // Slow heading drifts with random content, occasional gusts that refill the
  // window and stray samples; each phase runs under its own offset
  task automatic check_random_walks();
    int phase;
    int n;
    int pick;
    int center;
    int raw;
    for (phase = 0; phase < WALK_PHASES; phase++) begin
      case (phase)
        0:       write_reg(OFFSET_ADDR, DATA_W'(OFFSET_LIMIT));
        1:       write_reg(OFFSET_ADDR, DATA_W'(-OFFSET_LIMIT));
        2:       write_reg(OFFSET_ADDR, '0);
        default: write_reg(OFFSET_ADDR, DATA_W'($urandom()));
      endcase
      center = mean_q6 * COUNT_TO_Q6_DEN / COUNT_TO_Q6_NUM;
      for (n = 0; n < PHASE_BEATS; n++) begin
        // Hold off once until the result queue is empty, then resume
        if (phase == 1 && n == PHASE_BEATS / 2) wait_for_drain();
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          center = $urandom_range(0, int'(RAW_MAX));
          raw = center;
        end else if (pick < 10) begin
          raw = $urandom_range(0, int'(RAW_MAX));
        end else begin
          center = center + int'($urandom_range(0, 60)) - 30;
          if (center < 0) center = 0;
          if (center > int'(RAW_MAX)) center = int'(RAW_MAX);
          raw = center;
        end
        send_angle(RAW_W'(raw));
      end
    end
  endtask

  // Receiver: pop steps through a 32-bit pattern that is redrawn each time pop_tick wraps,
  // from never stalling to stalling most of the time
  always @(negedge clk) begin
    if (pop_tick == 0) begin
      case ($urandom_range(0, 3))
        0:       pop_pattern = '1;
        1:       pop_pattern = $urandom();
        2:       pop_pattern = $urandom() | $urandom();
        default: pop_pattern = $urandom() & $urandom();
      endcase
    end
    pop <= pop_pattern[pop_tick[4:0]];
    pop_tick = pop_tick + 1'b1;
  end

  // Compare each popped result beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_headings.size() == 0) begin
        $error("unexpected result beat: heading_q6=%0d sector=%0d jump_reset=%0d",
               heading_q6, sector, jump_reset);
        fail_count++;
      end else begin
        oldest_heading = pending_headings.pop_front();
        headings_checked++;
        if (heading_q6 !== oldest_heading.heading_q6) begin
          $error("heading_q6: expected %0d, got %0d", oldest_heading.heading_q6, heading_q6);
          fail_count++;
        end
        if (sector !== oldest_heading.sector) begin
          $error("sector: expected %0d, got %0d", oldest_heading.sector, sector);
          fail_count++;
        end
        if (jump_reset !== oldest_heading.jump_reset) begin
          $error("jump_reset: expected %0d, got %0d", oldest_heading.jump_reset, jump_reset);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #WATCHDOG_DELAY;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst       = 1'b1;
    push      = 1'b0;
    raw_angle = '0;
    pop       = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    pop_tick  = '0;
    pop_pattern = '1;
    foreach (window_q6[i]) window_q6[i] = 0;
    window_slot = 0;
    window_sum  = 0;
    mean_q6     = 0;
    offset_reg  = '0;
    burst_left  = 0;
    fail_count  = 0;
    samples_sent     = 0;
    headings_checked = 0;
    refill_count     = 0;
    offset_writes    = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    check_reset_state();
    check_jump_threshold();
    check_boundary_headings();
    check_offset_clamp();
    check_unmapped_write();
    check_random_walks();
    wait_for_drain();

    $display("Sent %0d samples (%0d window refills), checked %0d heading beats,",
             samples_sent, refill_count, headings_checked);
    $display("across %0d register writes including clamped and unmapped ones.",
             offset_writes);
    if (fail_count == 0 && pending_headings.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
+incdir+rtl
rtl/whf_pkg.sv
rtl/whf_front.sv
rtl/whf_queue.sv
rtl/whf_back.sv
rtl/wind_vane_heading_filter.sv
rtl/whf_checker.sv
sim/wind_vane_heading_filter_tb.sv
